// ===== src/dadd_pkg.sv =====
// shared types, microcode codes and month table for the date adder
package dadd_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 15;
    // running year may pass 16383 before truncation on output
    localparam int YACC_W  = 15;
    // day count: up to 366 days of year plus 32767 added days
    localparam int REM_W   = 16;
    localparam int PC_W    = 3;

    // year / 100 by reciprocal: q = (y * 5243) >> 19, exact below 16384
    localparam int RECIP_W      = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int QUOT_W       = 8;
    localparam int PROD_W       = YEAR_W + RECIP_W;
    localparam logic [6:0] CENTURY = 7'd100;
    localparam logic [6:0] LAST_OF_CENTURY = 7'd99;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    // datapath operations
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_MOD  = 3'd2;
    localparam logic [2:0] OP_DOY  = 3'd3;
    localparam logic [2:0] OP_ADD  = 3'd4;
    localparam logic [2:0] OP_WALK = 3'd5;
    localparam logic [2:0] OP_EMIT = 3'd6;

    // branch conditions
    localparam logic [1:0] BR_ALWAYS = 2'd0;
    localparam logic [1:0] BR_START  = 2'd1;
    localparam logic [1:0] BR_MHIT   = 2'd2;
    localparam logic [1:0] BR_REMLE  = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd1;
    localparam logic [PC_W-1:0] PC_MOD  = 3'd2;
    localparam logic [PC_W-1:0] PC_DOY  = 3'd3;
    localparam logic [PC_W-1:0] PC_ADD  = 3'd4;
    localparam logic [PC_W-1:0] PC_WALK = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd6;

    // one control word
    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      cond;
        logic [PC_W-1:0] jt;
        logic [PC_W-1:0] jf;
    } t_ctrl;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic mhit;
        logic remle;
    } t_stat;

    // days in a month, month already in 1..12
    function automatic logic [DAY_W-1:0] f_month_len(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/dadd_seq.sv =====
// microcode sequencer: step counter, control rom and branch logic
module dadd_seq
    import dadd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;
    logic            w_taken;

    // control rom
    always_comb begin
        case (r_pc)
            PC_IDLE: w_ctrl = '{op: OP_LOAD, cond: BR_START,  jt: PC_MUL,  jf: PC_IDLE};
            PC_MUL:  w_ctrl = '{op: OP_MUL,  cond: BR_ALWAYS, jt: PC_MOD,  jf: PC_MOD};
            PC_MOD:  w_ctrl = '{op: OP_MOD,  cond: BR_ALWAYS, jt: PC_DOY,  jf: PC_DOY};
            PC_DOY:  w_ctrl = '{op: OP_DOY,  cond: BR_MHIT,   jt: PC_ADD,  jf: PC_DOY};
            PC_ADD:  w_ctrl = '{op: OP_ADD,  cond: BR_ALWAYS, jt: PC_WALK, jf: PC_WALK};
            PC_WALK: w_ctrl = '{op: OP_WALK, cond: BR_REMLE,  jt: PC_EMIT, jf: PC_WALK};
            PC_EMIT: w_ctrl = '{op: OP_EMIT, cond: BR_ALWAYS, jt: PC_IDLE, jf: PC_IDLE};
            default: w_ctrl = '{op: OP_EMIT, cond: BR_ALWAYS, jt: PC_IDLE, jf: PC_IDLE};
        endcase
    end

    // branch condition select
    always_comb begin
        case (w_ctrl.cond)
            BR_ALWAYS: w_taken = 1'b1;
            BR_START:  w_taken = i_start;
            BR_MHIT:   w_taken = i_stat.mhit;
            BR_REMLE:  w_taken = i_stat.remle;
            default:   w_taken = 1'b1;
        endcase
        n_pc = w_taken ? w_ctrl.jt : w_ctrl.jf;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_busy = (r_pc != PC_IDLE);

endmodule

// ===== src/dadd_datapath.sv =====
// datapath: day counter, month and year counters, leap tracking
module dadd_datapath
    import dadd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_start,
    input  t_ctrl              i_ctrl,
    input  logic [DAY_W-1:0]   i_start_day,
    input  logic [MONTH_W-1:0] i_start_month,
    input  logic [YEAR_W-1:0]  i_start_year,
    input  logic [ADD_W-1:0]   i_days_to_add,
    output t_stat              o_stat,
    output logic [DAY_W-1:0]   o_day,
    output logic [MONTH_W-1:0] o_month,
    output logic [YEAR_W-1:0]  o_year
);

    logic [REM_W-1:0]   r_rem;
    logic [MONTH_W-1:0] r_month;
    logic [MONTH_W-1:0] r_smonth;
    logic [YACC_W-1:0]  r_year;
    logic [ADD_W-1:0]   r_add;
    logic [QUOT_W-1:0]  r_q;
    logic [6:0]         r_y100;
    logic [1:0]         r_c4;

    logic [PROD_W-1:0]  w_prod;
    logic [YEAR_W-1:0]  w_qx100;
    logic [YEAR_W-1:0]  w_ymod;
    logic               w_leap;
    logic [DAY_W-1:0]   w_len;
    logic [REM_W-1:0]   w_len_x;
    logic               w_mhit;
    logic               w_remle;
    logic [DAY_W-1:0]   w_day_in;
    logic [MONTH_W-1:0] w_month_in;

    // input clean-up: day 0 as 1, month 0 as January, above 12 as December
    always_comb begin
        w_day_in   = (i_start_day == '0) ? DAY_W'(1) : i_start_day;
        if (i_start_month == '0) begin
            w_month_in = JANUARY;
        end else if (i_start_month > DECEMBER) begin
            w_month_in = DECEMBER;
        end else begin
            w_month_in = i_start_month;
        end
    end

    // year / 100 and year mod 100
    assign w_prod  = r_year[YEAR_W-1:0] * RECIP_100;
    assign w_qx100 = YEAR_W'(r_q * CENTURY);
    assign w_ymod  = r_year[YEAR_W-1:0] - w_qx100;

    // leap: divisible by 4, and not by 100 unless by 400
    assign w_leap  = (r_year[1:0] == 2'd0) && ((r_y100 != 7'd0) || (r_c4 == 2'd0));
    assign w_len   = f_month_len(r_month, w_leap);
    assign w_len_x = REM_W'(w_len);
    assign w_mhit  = (r_month == r_smonth);
    assign w_remle = (r_rem <= w_len_x);

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_start) begin
                    r_rem    <= REM_W'(w_day_in);
                    r_month  <= JANUARY;
                    r_smonth <= w_month_in;
                    r_year   <= YACC_W'(i_start_year);
                    r_add    <= i_days_to_add;
                end
            end
            OP_MUL: begin
                r_q <= w_prod[RECIP_SHIFT +: QUOT_W];
            end
            OP_MOD: begin
                r_y100 <= w_ymod[6:0];
                r_c4   <= r_q[1:0];
            end
            OP_DOY: begin
                // add lengths of months before the start month
                if (!w_mhit) begin
                    r_rem   <= r_rem + w_len_x;
                    r_month <= r_month + MONTH_W'(1);
                end
            end
            OP_ADD: begin
                r_rem   <= r_rem + REM_W'(r_add);
                r_month <= JANUARY;
            end
            OP_WALK: begin
                // step one month, roll the year after december
                if (!w_remle) begin
                    r_rem <= r_rem - w_len_x;
                    if (r_month == DECEMBER) begin
                        r_month <= JANUARY;
                        r_year  <= r_year + YACC_W'(1);
                        if (r_y100 == LAST_OF_CENTURY) begin
                            r_y100 <= 7'd0;
                            r_c4   <= r_c4 + 2'd1;
                        end else begin
                            r_y100 <= r_y100 + 7'd1;
                        end
                    end else begin
                        r_month <= r_month + MONTH_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.mhit  = w_mhit;
    assign o_stat.remle = w_remle;
    assign o_day   = r_rem[DAY_W-1:0];
    assign o_month = r_month;
    assign o_year  = r_year[YEAR_W-1:0];

endmodule

// ===== src/date_add_days.sv =====
// top level of the gregorian date adder
//
// Adds a day count to a Gregorian date. A word is taken at a rising edge
// where start is high and busy is low; busy then stays high until the
// result has been shown. The result appears on o_end_day, o_end_month and
// o_end_year for exactly one cycle, marked by o_valid; the receiver cannot
// stall it and must take it in that cycle.
//
// After the accepting edge the sequencer steps through its states in order:
// MUL and MOD split the year by 100, DOY adds the lengths of the months
// before the start month, ADD adds the day count, WALK walks month by
// month, one month per cycle through the shared month-length lookup, and
// EMIT shows the result. Only one word is in flight at a time; busy drops
// in the cycle after o_valid, so a new word can be taken then.
//
// Reset (synchronous, active low) returns the sequencer to idle; any word in
// progress is dropped and no result is produced for it.
module date_add_days
    import dadd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DAY_W-1:0]   i_start_day,
    input  logic [MONTH_W-1:0] i_start_month,
    input  logic [YEAR_W-1:0]  i_start_year,
    input  logic [ADD_W-1:0]   i_days_to_add,
    output logic               o_valid,
    output logic [DAY_W-1:0]   o_end_day,
    output logic [MONTH_W-1:0] o_end_month,
    output logic [YEAR_W-1:0]  o_end_year
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    // sequencer
    dadd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    // datapath
    dadd_datapath u_dp (
        .i_clk         (i_clk),
        .i_start       (start),
        .i_ctrl        (w_ctrl),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_days_to_add (i_days_to_add),
        .o_stat        (w_stat),
        .o_day         (o_end_day),
        .o_month       (o_end_month),
        .o_year        (o_end_year)
    );

    // result strobe
    assign o_valid = (w_ctrl.op == OP_EMIT);

    // checks
    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("sequencer not idle after result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_end_month >= JANUARY) && (o_end_month <= DECEMBER))
        else $error("result month out of range");

    a_valid_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_end_day != '0))
        else $error("result day is zero");

endmodule
